@@ sv/wmsc_pkg.sv @@
// shared types and constants for the watch mode stopwatch controller
package wmsc_pkg;

	// event codes carried on the input stream
	typedef enum logic [2:0] {
		FUNC_TICK       = 3'd0,
		FUNC_SCREEN_BTN = 3'd1,
		FUNC_SW_BTN     = 3'd2,
		FUNC_LINK_SCR   = 3'd3,
		FUNC_LINK_RST   = 3'd4,
		FUNC_LINK_TGL   = 3'd5
	} func_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_FIRST_DEB  = 2'd0,
		CFG_SECOND_DEB = 2'd1,
		CFG_DEMO_EN    = 2'd2,
		CFG_DEMO_INTV  = 2'd3
	} cfg_idx_t;

	typedef logic [1:0] screen_t;

	localparam screen_t SCREEN_DASH      = 2'd0;
	localparam screen_t SCREEN_STOPWATCH = 2'd3;

	localparam int TimeW    = 32;
	localparam int DebW     = 16;
	localparam int IntvW    = 24;
	localparam int SecondMs = 1000;
	localparam int SecCntW  = 10;

	localparam int InDataW  = 8;
	localparam int OutDataW = 40;
	localparam int CfgDataW = 24;

	localparam logic [SecCntW-1:0] SEC_LAST = SecCntW'(SecondMs - 1);

endpackage

@@ sv/watch_mode_stopwatch_controller.sv @@
// watch mode controller: tick, buttons, link events, stopwatch and screen state
//
//  channel   | ports                          | payload
//  ----------+--------------------------------+------------------------------------------
//  event in  | s_axis_tvalid/tready/tdata     | func[2:0], screen_request[4:3]
//  result out| m_axis_tvalid/tready/tdata     | screen, stopwatch_value_ms, flags
//  config    | cfg_valid/cfg_ready/index/data | one register per transaction
//
// one event per cycle while the result register is not stalled: an event is held in the
// input register, the state update and result are computed from it and land in the result register.
// result valid once the event has moved from the input register into the result register.
// reset returns every register to its power-on value; config is always ready.
// a stalled result register holds the input register; input keeps flowing while
// the input register is empty or moving on.
module watch_mode_stopwatch_controller
	import wmsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// event stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,   // [2:0] func, [4:3] screen_request, rest zero
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,   // [1:0] screen, [33:2] stopwatch_value_ms,
	                                            // [34] stopwatch_running, [35] second_elapsed,
	                                            // [36] screen_switched, [37] redraw_request,
	                                            // [38] press_accepted, [39] zero
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// configuration registers
	logic [DebW-1:0]  first_deb_q;
	logic [DebW-1:0]  second_deb_q;
	logic             demo_q;
	logic [IntvW-1:0] intv_q;

	// controller state
	logic [TimeW-1:0]   sys_q;
	logic [SecCntW-1:0] sec_cnt_q;
	logic [TimeW-1:0]   sw_q;
	logic               run_q;
	screen_t            scr_q;
	logic               first_seen_q;
	logic [TimeW-1:0]   first_last_q;
	logic               second_seen_q;
	logic [TimeW-1:0]   second_last_q;
	logic [TimeW-1:0]   auto_last_q;

	// input register
	logic       valid_s1;
	logic [2:0] func_s1;
	screen_t    req_s1;

	// result register
	logic               out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	logic advance;
	logic take_in;
	logic step;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;
	assign step          = valid_s1 && advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// next state and result of the event in the input register
	logic [TimeW-1:0]   sys_n;
	logic [SecCntW-1:0] sec_cnt_n;
	logic [TimeW-1:0]   sw_n;
	logic               run_n;
	screen_t            scr_n;
	logic               first_seen_n;
	logic [TimeW-1:0]   first_last_n;
	logic               second_seen_n;
	logic [TimeW-1:0]   second_last_n;
	logic [TimeW-1:0]   auto_last_n;
	logic               second_f;
	logic               redraw_f;
	logic               accept_f;
	logic               do_cycle;
	logic [TimeW-1:0]   sys_inc;
	logic [TimeW-1:0]   cycle_now;
	logic               deb1_ok;
	logic               deb2_ok;
	logic               demo_due;

	assign sys_inc  = sys_q + TimeW'(1);
	assign deb1_ok  = !first_seen_q ||
		((sys_q - first_last_q) >= TimeW'(first_deb_q));
	assign deb2_ok  = !second_seen_q ||
		((sys_q - second_last_q) >= TimeW'(second_deb_q));
	assign demo_due = demo_q && ((sys_inc - auto_last_q) >= TimeW'(intv_q));

	always_comb begin
		sys_n         = sys_q;
		sec_cnt_n     = sec_cnt_q;
		sw_n          = sw_q;
		run_n         = demo_q ? 1'b1 : run_q;
		scr_n         = scr_q;
		first_seen_n  = first_seen_q;
		first_last_n  = first_last_q;
		second_seen_n = second_seen_q;
		second_last_n = second_last_q;
		auto_last_n   = auto_last_q;
		second_f      = 1'b0;
		redraw_f      = 1'b0;
		accept_f      = 1'b0;
		do_cycle      = 1'b0;
		cycle_now     = sys_q;

		case (func_s1)
			FUNC_TICK: begin
				sys_n = sys_inc;
				// ms within second, realigned when system time wraps to zero
				if (sys_q == '1 || sec_cnt_q == SEC_LAST) begin
					sec_cnt_n = '0;
				end else begin
					sec_cnt_n = sec_cnt_q + SecCntW'(1);
				end
				second_f = (sec_cnt_n == '0);
				if (run_n) begin
					sw_n = sw_q + TimeW'(1);
				end
				cycle_now = sys_inc;
				if (demo_due) begin
					do_cycle = 1'b1;
					redraw_f = 1'b1;
				end
			end
			FUNC_SCREEN_BTN: begin
				if (deb1_ok) begin
					first_seen_n = 1'b1;
					first_last_n = sys_q;
					accept_f     = 1'b1;
					do_cycle     = 1'b1;
					redraw_f     = 1'b1;
				end
			end
			FUNC_SW_BTN: begin
				if (deb2_ok) begin
					second_seen_n = 1'b1;
					second_last_n = sys_q;
					accept_f      = 1'b1;
					if (scr_q == SCREEN_STOPWATCH) begin
						run_n    = demo_q ? 1'b1 : !run_n;
						redraw_f = 1'b1;
					end
				end
			end
			FUNC_LINK_SCR: begin
				scr_n    = req_s1;
				redraw_f = 1'b1;
			end
			FUNC_LINK_RST: begin
				if (!demo_q) begin
					sw_n  = '0;
					run_n = 1'b0;
				end
				scr_n    = SCREEN_STOPWATCH;
				redraw_f = 1'b1;
			end
			FUNC_LINK_TGL: begin
				scr_n    = SCREEN_STOPWATCH;
				run_n    = demo_q ? 1'b1 : !run_n;
				redraw_f = 1'b1;
			end
			default: begin
			end
		endcase

		// screen button or demo advance action: reset a busy stopwatch screen outside demo mode, else advance
		if (do_cycle) begin
			auto_last_n = cycle_now;
			if (!demo_q && scr_q == SCREEN_STOPWATCH && (sw_n != '0 || run_n)) begin
				sw_n  = '0;
				run_n = 1'b0;
			end else begin
				scr_n = scr_q + screen_t'(1);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_deb_q  <= DebW'(200);
			second_deb_q <= DebW'(200);
			demo_q       <= 1'b0;
			intv_q       <= IntvW'(15000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIRST_DEB:  first_deb_q  <= cfg_data[DebW-1:0];
				CFG_SECOND_DEB: second_deb_q <= cfg_data[DebW-1:0];
				CFG_DEMO_EN:    demo_q       <= cfg_data[0];
				CFG_DEMO_INTV:  intv_q       <= cfg_data[IntvW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			func_s1  <= '0;
			req_s1   <= SCREEN_DASH;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			if (take_in) begin
				func_s1 <= s_axis_tdata[2:0];
				req_s1  <= s_axis_tdata[4:3];
			end
		end
	end

	// controller state update, one event per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q         <= '0;
			sec_cnt_q     <= '0;
			sw_q          <= '0;
			run_q         <= 1'b0;
			scr_q         <= SCREEN_DASH;
			first_seen_q  <= 1'b0;
			first_last_q  <= '0;
			second_seen_q <= 1'b0;
			second_last_q <= '0;
			auto_last_q   <= '0;
		end else if (step) begin
			sys_q         <= sys_n;
			sec_cnt_q     <= sec_cnt_n;
			sw_q          <= sw_n;
			run_q         <= run_n;
			scr_q         <= scr_n;
			first_seen_q  <= first_seen_n;
			first_last_q  <= first_last_n;
			second_seen_q <= second_seen_n;
			second_last_q <= second_last_n;
			auto_last_q   <= auto_last_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
		end else if (step) begin
			out_data_q <= {1'b0, accept_f, redraw_f, (scr_n != scr_q), second_f,
				run_n, sw_n, scr_n};
		end
	end

`ifndef SYNTHESIS
	// ms-within-second counter never leaves its range
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_cnt_q <= SEC_LAST)
		else $error("second counter out of range");

	// an event waiting behind a stalled result is not dropped
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register lost an event");

	// demo mode leaves the stopwatch running after every event
	a_demo_run: assert property (@(posedge clk) disable iff (!arst_n)
		(step && demo_q) |=> run_q)
		else $error("stopwatch stopped in demo mode");

	// a screen change always comes with a redraw
	a_change_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[36]) |-> out_data_q[37])
		else $error("screen change without redraw");

	// once a press was accepted the first-press mark stays
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		first_seen_q |=> first_seen_q)
		else $error("first press mark cleared");
`endif

endmodule

@@ bench/watch_mode_stopwatch_controller_test.sv @@
// self-checking stream testbench for the watch mode stopwatch controller
module watch_mode_stopwatch_controller_test;
	import wmsc_pkg::*;

	// event codes the block must ignore
	localparam logic [2:0] FUNC_UNDEF_LO = 3'd6;
	localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;

	// button slots in the debounce tables
	localparam int BTN_SCREEN = 0;
	localparam int BTN_SW     = 1;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 250;
	localparam int HOLD_AT     = 600;

	// result layout, lowest field last
	typedef struct packed {
		logic               pad;
		logic               press_ok;
		logic               redraw;
		logic               changed;
		logic               sec_tick;
		logic               running;
		logic [TimeW-1:0]   sw_ms;
		screen_t            screen;
	} watch_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	watch_mode_stopwatch_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock and reset
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// predicted controller state and settings
	logic [TimeW-1:0] clk_ms = '0;
	logic [TimeW-1:0] sw_ms = '0;
	logic             sw_run = 1'b0;
	screen_t          cur_screen = SCREEN_DASH;
	logic             btn_seen [2] = '{1'b0, 1'b0};
	logic [TimeW-1:0] btn_last [2] = '{'0, '0};
	logic [DebW-1:0]  btn_debounce [2] = '{16'd200, 16'd200};
	logic [TimeW-1:0] auto_mark = '0;
	logic             demo_on = 1'b0;
	logic [IntvW-1:0] demo_period = 24'd15000;

	// traffic bookkeeping
	logic [InDataW-1:0] event_queue [$];
	watch_result_t      expected_results [$];
	logic               event_taken = 1'b0;
	logic               idle_en = 1'b1;
	logic               long_hold_done = 1'b0;
	int                 hold_left = 0;
	int                 errors = 0;
	int                 progress = 0;
	int                 events_sent = 0;
	int                 results_seen = 0;
	int                 settings_count = 0;
	int                 whole_seconds = 0;
	int                 presses_ok = 0;
	int                 auto_advances = 0;
	int                 screen_changes = 0;

	// screen button action: clear a busy stopwatch, otherwise next screen
	function automatic void screen_step(logic [TimeW-1:0] stamp);
		auto_mark = stamp;
		if (!demo_on && cur_screen == SCREEN_STOPWATCH && (sw_ms != 0 || sw_run)) begin
			sw_ms = '0;
			sw_run = 1'b0;
		end else begin
			cur_screen = cur_screen + 2'd1;
		end
	endfunction

	// first press always passes, later ones need the debounce time
	function automatic logic debounce_pass(int b, logic [TimeW-1:0] stamp);
		logic [TimeW-1:0] elapsed;
		elapsed = stamp - btn_last[b];
		if (!btn_seen[b] || elapsed >= TimeW'(btn_debounce[b])) begin
			btn_seen[b] = 1'b1;
			btn_last[b] = stamp;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the predicted state by one event and form its result
	function automatic watch_result_t apply_watch_event(logic [2:0] code, screen_t req);
		watch_result_t    r;
		screen_t          prior;
		logic [TimeW-1:0] stamp;
		logic [TimeW-1:0] since_auto;
		logic             sec;
		logic             redraw;
		logic             press;
		prior = cur_screen;
		stamp = clk_ms;
		sec = 1'b0;
		redraw = 1'b0;
		press = 1'b0;
		if (demo_on)
			sw_run = 1'b1;
		case (code)
			FUNC_TICK: begin
				clk_ms = clk_ms + 1;
				stamp = clk_ms;
				if (sw_run)
					sw_ms = sw_ms + 1;
				if (stamp % SecondMs == 0)
					sec = 1'b1;
				since_auto = stamp - auto_mark;
				if (demo_on && since_auto >= TimeW'(demo_period)) begin
					screen_step(stamp);
					redraw = 1'b1;
					auto_advances++;
				end
			end
			FUNC_SCREEN_BTN: begin
				if (debounce_pass(BTN_SCREEN, stamp)) begin
					press = 1'b1;
					screen_step(stamp);
					redraw = 1'b1;
				end
			end
			FUNC_SW_BTN: begin
				if (debounce_pass(BTN_SW, stamp)) begin
					press = 1'b1;
					if (cur_screen == SCREEN_STOPWATCH) begin
						sw_run = demo_on ? 1'b1 : !sw_run;
						redraw = 1'b1;
					end
				end
			end
			FUNC_LINK_SCR: begin
				cur_screen = req;
				redraw = 1'b1;
			end
			FUNC_LINK_RST: begin
				if (demo_on) begin
					sw_run = 1'b1;
				end else begin
					sw_ms = '0;
					sw_run = 1'b0;
				end
				cur_screen = SCREEN_STOPWATCH;
				redraw = 1'b1;
			end
			FUNC_LINK_TGL: begin
				cur_screen = SCREEN_STOPWATCH;
				sw_run = demo_on ? 1'b1 : !sw_run;
				redraw = 1'b1;
			end
			default: ;
		endcase
		r.pad = 1'b0;
		r.press_ok = press;
		r.redraw = redraw;
		r.changed = (cur_screen != prior);
		r.sec_tick = sec;
		r.running = sw_run;
		r.sw_ms = sw_ms;
		r.screen = cur_screen;
		whole_seconds += int'(sec);
		presses_ok += int'(press);
		screen_changes += int'(r.changed);
		return r;
	endfunction

	function automatic void check_field(string what, logic [TimeW-1:0] want,
			logic [TimeW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	function automatic void queue_event(logic [2:0] code, screen_t req);
		event_queue.push_back({3'b000, req, code});
	endfunction

	// bursts of ticks, each closed by one button, link or undefined event
	function automatic void queue_random(int n, int gap_max);
		int         added;
		int         pick;
		logic [2:0] code;
		added = 0;
		while (added < n) begin
			repeat ($urandom_range(gap_max)) begin
				queue_event(FUNC_TICK, screen_t'($urandom_range(3)));
				added++;
			end
			pick = $urandom_range(99);
			if (pick < 30)
				code = FUNC_SCREEN_BTN;
			else if (pick < 60)
				code = FUNC_SW_BTN;
			else if (pick < 72)
				code = FUNC_LINK_SCR;
			else if (pick < 82)
				code = FUNC_LINK_RST;
			else if (pick < 92)
				code = FUNC_LINK_TGL;
			else
				code = $urandom_range(1) ? FUNC_UNDEF_HI : FUNC_UNDEF_LO;
			queue_event(code, screen_t'($urandom_range(3)));
			if (code != FUNC_UNDEF_LO && code != FUNC_UNDEF_HI)
				added++;
		end
	endfunction

	// one register write, applied to the predictor on its transaction
	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		progress++;
		case (idx)
			CFG_FIRST_DEB:  btn_debounce[BTN_SCREEN] = value[DebW-1:0];
			CFG_SECOND_DEB: btn_debounce[BTN_SW] = value[DebW-1:0];
			CFG_DEMO_EN:    demo_on = value[0];
			CFG_DEMO_INTV:  demo_period = value[IntvW-1:0];
			default: ;
		endcase
	endtask

	// all four registers, unused upper bits filled with noise
	task automatic write_settings(logic [DebW-1:0] deb_scr, logic [DebW-1:0] deb_sw,
			logic demo, logic [IntvW-1:0] period);
		write_reg(CFG_FIRST_DEB, {8'($urandom), deb_scr});
		write_reg(CFG_SECOND_DEB, {8'($urandom), deb_sw});
		write_reg(CFG_DEMO_EN, {23'($urandom), demo});
		write_reg(CFG_DEMO_INTV, period);
		@(negedge clk) cfg_valid <= 1'b0;
		@(posedge clk);
		settings_count++;
	endtask

	task automatic wait_drained();
		while (event_queue.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// input driver: hold an untaken item, else offer the next one or idle
	always @(negedge clk) begin
		if (!s_axis_tvalid || event_taken) begin
			if (event_queue.size() != 0 && !(idle_en && $urandom_range(99) < 10)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= event_queue[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// input transaction: predict its result
	always @(posedge clk) begin
		event_taken = s_axis_tvalid && s_axis_tready;
		if (event_taken) begin
			void'(event_queue.pop_front());
			expected_results.push_back(apply_watch_event(s_axis_tdata[2:0], s_axis_tdata[4:3]));
			events_sent++;
			progress++;
		end
	end

	// result receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!long_hold_done && results_seen >= HOLD_AT) begin
			hold_left = LONG_HOLD;
			long_hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idle_en && $urandom_range(99) < 10);
		end
	end

	// result transaction: compare with the oldest prediction
	always @(posedge clk) begin : result_check
		watch_result_t got;
		watch_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			results_seen++;
			progress++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result %0h with no event pending", $time, m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("screen", TimeW'(want.screen), TimeW'(got.screen));
				check_field("stopwatch_value_ms", want.sw_ms, got.sw_ms);
				check_field("stopwatch_running", TimeW'(want.running), TimeW'(got.running));
				check_field("second_elapsed", TimeW'(want.sec_tick), TimeW'(got.sec_tick));
				check_field("screen_switched", TimeW'(want.changed), TimeW'(got.changed));
				check_field("redraw_request", TimeW'(want.redraw), TimeW'(got.redraw));
				check_field("press_accepted", TimeW'(want.press_ok), TimeW'(got.press_ok));
				check_field("padding bit", TimeW'(want.pad), TimeW'(got.pad));
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int quiet;
		int seen;
		quiet = 0;
		seen = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (progress != seen) begin
				seen = progress;
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("watch_mode_stopwatch_controller_test failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// directed: reset settings, every event kind, debounce rejects
		queue_event(FUNC_TICK, SCREEN_DASH);
		queue_event(FUNC_UNDEF_LO, SCREEN_STOPWATCH);
		queue_event(FUNC_UNDEF_HI, screen_t'(1));
		queue_event(FUNC_SCREEN_BTN, SCREEN_DASH);
		queue_event(FUNC_SCREEN_BTN, SCREEN_STOPWATCH);
		queue_event(FUNC_SW_BTN, SCREEN_DASH);
		for (int s = 0; s < 4; s++)
			queue_event(FUNC_LINK_SCR, screen_t'(s));
		queue_event(FUNC_SCREEN_BTN, SCREEN_DASH);
		queue_event(FUNC_SW_BTN, SCREEN_DASH);
		queue_event(FUNC_LINK_TGL, SCREEN_DASH);
		repeat (3) queue_event(FUNC_TICK, SCREEN_STOPWATCH);
		queue_event(FUNC_LINK_TGL, screen_t'(2));
		queue_event(FUNC_LINK_RST, SCREEN_DASH);
		queue_event(FUNC_LINK_TGL, SCREEN_DASH);
		queue_event(FUNC_TICK, SCREEN_DASH);
		queue_event(FUNC_LINK_SCR, screen_t'(2));
		queue_event(FUNC_LINK_RST, screen_t'(1));
		wait_drained();

		// short debounce, normal mode
		write_settings(16'd3, 16'd5, 1'b0, 24'd15000);
		queue_random(230, 16);
		wait_drained();

		// no debounce, demo advancing on every tick
		write_settings(16'd0, 16'd0, 1'b1, 24'd1);
		queue_random(200, 6);
		wait_drained();

		// longest debounce, zero demo interval
		write_settings(16'hFFFF, 16'hFFFF, 1'b1, 24'd0);
		queue_random(170, 4);
		wait_drained();

		// normal mode, longest interval; sender pauses until drained halfway
		write_settings(16'($urandom_range(30)), 16'($urandom_range(30)), 1'b0, 24'hFFFFFF);
		queue_random(120, 10);
		wait_drained();
		queue_random(120, 10);
		wait_drained();

		// no idling on either side, demo with a short interval
		idle_en <= 1'b0;
		write_settings(16'd8, 16'd2, 1'b1, 24'd7);
		queue_random(200, 8);
		wait_drained();
		idle_en <= 1'b1;

		// demo with the longest interval
		write_settings(16'd1, 16'd1, 1'b1, 24'hFFFFFF);
		queue_random(180, 12);
		wait_drained();

		// back to normal mode with the stopwatch left running
		write_settings(16'd4, 16'd4, 1'b0, 24'd15000);
		queue_random(130, 12);
		wait_drained();

		repeat (6) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		end
		$display("%0d events over %0d register settings, %0d results checked",
			events_sent, settings_count, results_seen);
		$display("%0d whole seconds, %0d accepted presses, %0d demo advances, %0d screen changes",
			whole_seconds, presses_ok, auto_advances, screen_changes);
		if (errors == 0)
			$display("watch_mode_stopwatch_controller_test passed");
		else
			$display("watch_mode_stopwatch_controller_test failed");
		$finish;
	end

endmodule

@@ watch_mode_stopwatch_controller.f @@
sv/wmsc_pkg.sv
sv/watch_mode_stopwatch_controller.sv
bench/watch_mode_stopwatch_controller_test.sv
